>>> rtl/rlbc_pkg.sv
`default_nettype none

package rlbc_pkg;

    // Widths of the request and result fields.
    localparam int IN_W  = 9;
    localparam int VAL_W = 30;

    // Default largest symbol count held by the tables.
    localparam int MAX_SYMBOLS_DEFAULT = 256;

    // Modulus of every count.
    localparam logic [VAL_W-1:0] PRIME_MOD = VAL_W'(1000000007);

    // Widen a flag into a count of zero or one.
    function automatic logic [VAL_W-1:0] flag_to_val(input logic flag);
        return {{(VAL_W-1){1'b0}}, flag};
    endfunction

endpackage

`default_nettype wire

>>> rtl/run_limited_binary_count_top.sv
`default_nettype none

// Counts binary sequences with zero_count zeros and one_count ones in which
// no run of equal symbols is longer than run_limit, modulo 1000000007. Counts
// above MAX_SYMBOLS saturate at MAX_SYMBOLS, and an empty sequence answers 2.
// One request at a time: after a transfer the block fills two tables of
// (MAX_SYMBOLS+1) squared cells, split by last symbol, through a single
// shared modular add/subtract unit that is used twice per cell. Each table
// row begins with a read state that fetches the operands of its first
// cell; a request with a zero count skips the tables and goes straight to
// its final state. The tables need no clearing after reset, since a request
// uses only cells that it has written itself. A finished result waits in
// the output register while the next request is taken. If that next
// request finishes while the earlier result is still waiting, it holds in
// its last cycle until the earlier result is taken.
module run_limited_binary_count_top #(
    parameter int MAX_SYMBOLS = rlbc_pkg::MAX_SYMBOLS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rlbc_pkg::IN_W-1:0]   zero_count,
    input  wire logic [rlbc_pkg::IN_W-1:0]   one_count,
    input  wire logic [rlbc_pkg::IN_W-1:0]   run_limit,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [rlbc_pkg::VAL_W-1:0]  sequence_count
);
    import rlbc_pkg::*;

    localparam int SIDE   = MAX_SYMBOLS + 1;
    localparam int IDX_W  = $clog2(SIDE);
    localparam int CNT_W  = ((IDX_W > IN_W) ? IDX_W : IN_W) + 1;
    localparam int DEPTH  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC_Z,
        ST_CALC_O,
        ST_FINAL
    } state_t;

    state_t           state_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] seq_count_reg;

    logic [CNT_W-1:0] nz_reg;
    logic [CNT_W-1:0] no_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [VAL_W-1:0] cur_z_reg;
    logic [VAL_W-1:0] left_z_reg;
    logic [VAL_W-1:0] left_o_reg;

    logic [CNT_W-1:0] zc_sat;
    logic [CNT_W-1:0] oc_sat;
    logic [CNT_W-1:0] lim_in;
    logic             in_xfer;
    logic             out_xfer;
    logic             out_free;
    logic             row_last;
    logic             rd_en;

    logic [CNT_W-1:0] rd_i;
    logic [CNT_W-1:0] rd_j;
    logic [CNT_W-1:0] drop_row;
    logic [CNT_W-1:0] drop_col;
    logic [ADDR_W-1:0] up_addr;
    logic [ADDR_W-1:0] o_drop_addr;
    logic [ADDR_W-1:0] z_drop_addr;
    logic [ADDR_W-1:0] cell_waddr;

    logic [VAL_W-1:0] z_up;
    logic [VAL_W-1:0] z_drop;
    logic [VAL_W-1:0] o_up;
    logic [VAL_W-1:0] o_drop;
    logic [VAL_W-1:0] unit_a;
    logic [VAL_W-1:0] unit_b;
    logic [VAL_W-1:0] unit_c;
    logic [VAL_W-1:0] unit_res;

    // Linear address of a table cell.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [CNT_W-1:0] row,
        input logic [CNT_W-1:0] col
    );
        return ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
    endfunction

    // Handshakes and request decode.
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign row_last = (j_reg == no_reg);
    assign rd_en    = (state_reg == ST_READ) || ((state_reg == ST_CALC_O) && !row_last);

    assign out_valid      = out_valid_reg;
    assign sequence_count = seq_count_reg;

    always_comb
    begin
        zc_sat = CNT_W'(zero_count);
        oc_sat = CNT_W'(one_count);
        lim_in = CNT_W'(run_limit);
        if (CNT_W'(zero_count) > CNT_W'(MAX_SYMBOLS))
        begin
            zc_sat = CNT_W'(MAX_SYMBOLS);
        end
        if (CNT_W'(one_count) > CNT_W'(MAX_SYMBOLS))
        begin
            oc_sat = CNT_W'(MAX_SYMBOLS);
        end
    end

    // Read addresses for the cell whose operands are fetched this cycle:
    // the current cell from the read state, the next one in the row otherwise.
    always_comb
    begin
        rd_i     = i_reg;
        rd_j     = (state_reg == ST_READ) ? j_reg : j_reg + CNT_W'(1);
        drop_row = (rd_i > lim_reg) ? rd_i - CNT_W'(1) - lim_reg : '0;
        drop_col = (rd_j > lim_reg) ? rd_j - CNT_W'(1) - lim_reg : '0;
        up_addr     = cell_addr(rd_i - CNT_W'(1), rd_j);
        o_drop_addr = cell_addr(drop_row, rd_j);
        z_drop_addr = cell_addr(rd_i, drop_col);
        cell_waddr  = cell_addr(i_reg, j_reg);
    end

    rlbc_table_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ends_zero (
        .clk     (clk),
        .we      (state_reg == ST_CALC_Z),
        .waddr   (cell_waddr),
        .wdata   (unit_res),
        .re      (rd_en),
        .raddr_a (up_addr),
        .raddr_b (z_drop_addr),
        .rdata_a (z_up),
        .rdata_b (z_drop)
    );

    rlbc_table_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ends_one (
        .clk     (clk),
        .we      (state_reg == ST_CALC_O),
        .waddr   (cell_waddr),
        .wdata   (unit_res),
        .re      (rd_en),
        .raddr_a (up_addr),
        .raddr_b (o_drop_addr),
        .rdata_a (o_up),
        .rdata_b (o_drop)
    );

    // Operand selection for the shared unit; border cells are formed here
    // instead of being read from the tables.
    always_comb
    begin
        unit_a = left_z_reg;
        unit_b = left_o_reg;
        unit_c = '0;
        case (state_reg)
            ST_CALC_Z:
            begin
                if (i_reg == CNT_W'(1))
                begin
                    unit_a = '0;
                    unit_b = flag_to_val(j_reg <= lim_reg);
                end
                else
                begin
                    unit_a = z_up;
                    unit_b = o_up;
                end
                if (i_reg > lim_reg)
                begin
                    unit_c = (i_reg == lim_reg + CNT_W'(1)) ?
                             flag_to_val(j_reg <= lim_reg) : o_drop;
                end
            end
            ST_CALC_O:
            begin
                if (j_reg > lim_reg)
                begin
                    unit_c = (j_reg == lim_reg + CNT_W'(1)) ?
                             flag_to_val(i_reg <= lim_reg) : z_drop;
                end
            end
            default:
            begin
                unit_c = '0;
            end
        endcase
    end

    rlbc_addsub_mod u_unit (
        .a      (unit_a),
        .b      (unit_b),
        .c      (unit_c),
        .result (unit_res)
    );

    // Sequencer state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            seq_count_reg <= '0;
        end
        else
        begin
            if (out_xfer && (state_reg != ST_FINAL))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if ((zc_sat == '0) || (oc_sat == '0))
                        begin
                            state_reg <= ST_FINAL;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CALC_Z;
                end
                ST_CALC_Z:
                begin
                    state_reg <= ST_CALC_O;
                end
                ST_CALC_O:
                begin
                    if (!row_last)
                    begin
                        state_reg <= ST_CALC_Z;
                    end
                    else if (i_reg == nz_reg)
                    begin
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        seq_count_reg <= unit_res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Cell position and the values carried along a row.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    nz_reg  <= zc_sat;
                    no_reg  <= oc_sat;
                    lim_reg <= lim_in;
                    i_reg   <= CNT_W'(1);
                    j_reg   <= CNT_W'(1);
                    if ((zc_sat == '0) || (oc_sat == '0))
                    begin
                        left_z_reg <= (oc_sat == '0) ? flag_to_val(zc_sat <= lim_in) : '0;
                        left_o_reg <= (zc_sat == '0) ? flag_to_val(oc_sat <= lim_in) : '0;
                    end
                    else
                    begin
                        left_z_reg <= flag_to_val(CNT_W'(1) <= lim_in);
                        left_o_reg <= '0;
                    end
                end
            end
            ST_CALC_Z:
            begin
                cur_z_reg <= unit_res;
            end
            ST_CALC_O:
            begin
                if (row_last && (i_reg != nz_reg))
                begin
                    i_reg      <= i_reg + CNT_W'(1);
                    j_reg      <= CNT_W'(1);
                    left_z_reg <= flag_to_val((i_reg + CNT_W'(1)) <= lim_reg);
                    left_o_reg <= '0;
                end
                else
                begin
                    if (!row_last)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                    end
                    left_z_reg <= cur_z_reg;
                    left_o_reg <= unit_res;
                end
            end
            default:
            begin
                cur_z_reg <= cur_z_reg;
            end
        endcase
    end

`ifndef SYNTH
    // A transfer starts a request, so the block is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a request is in progress");

    // Every presented count is already reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sequence_count < PRIME_MOD))
        else $error("result not reduced modulo the prime");

    // The cell being computed lies inside the requested table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC_Z || state_reg == ST_CALC_O) |->
        (i_reg >= CNT_W'(1)) && (i_reg <= nz_reg) &&
        (j_reg >= CNT_W'(1)) && (j_reg <= no_reg))
        else $error("table cell outside the request");

    // A pending result is not overwritten before its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sequence_count))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

>>> rtl/rlbc_addsub_mod.sv
`default_nettype none

module rlbc_addsub_mod (
    input  wire logic [rlbc_pkg::VAL_W-1:0] a,
    input  wire logic [rlbc_pkg::VAL_W-1:0] b,
    input  wire logic [rlbc_pkg::VAL_W-1:0] c,
    output logic      [rlbc_pkg::VAL_W-1:0] result
);
    import rlbc_pkg::*;

    localparam int SUM_W = VAL_W + 2;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] mod1;
    logic [SUM_W-1:0] mod2;

    // All operands are below the modulus, so the raw sum stays below three times it.
    always_comb
    begin
        mod1   = SUM_W'(PRIME_MOD);
        mod2   = mod1 + mod1;
        sum    = SUM_W'(a) + SUM_W'(b) + mod1 - SUM_W'(c);
        result = a;
        if (sum >= mod2)
        begin
            result = VAL_W'(sum - mod2);
        end
        else if (sum >= mod1)
        begin
            result = VAL_W'(sum - mod1);
        end
        else
        begin
            result = VAL_W'(sum);
        end
    end

endmodule

`default_nettype wire

>>> rtl/rlbc_table_mem.sv
`default_nettype none

module rlbc_table_mem #(
    parameter int DEPTH  = 66049,
    parameter int ADDR_W = 17
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [ADDR_W-1:0]            waddr,
    input  wire logic [rlbc_pkg::VAL_W-1:0]   wdata,
    input  wire logic                         re,
    input  wire logic [ADDR_W-1:0]            raddr_a,
    input  wire logic [ADDR_W-1:0]            raddr_b,
    output logic      [rlbc_pkg::VAL_W-1:0]   rdata_a,
    output logic      [rlbc_pkg::VAL_W-1:0]   rdata_b
);
    import rlbc_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports; the data holds between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/run_limited_binary_count_top_tb.sv
`default_nettype none

module run_limited_binary_count_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rlbc_pkg::*;

    localparam int MAX_SYM = MAX_SYMBOLS_DEFAULT;
    localparam int SIDE = MAX_SYM + 1;

    // The receiver's long hold starts once this many results have arrived.
    localparam int HOLD_AT_RESULT = 30;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IN_W-1:0] zeros;
        logic [IN_W-1:0] ones;
        logic [IN_W-1:0] limit;
    } count_request_t;

    typedef struct packed {
        count_request_t req;
        logic [VAL_W-1:0] count;
    } expected_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [IN_W-1:0] zero_count = '0;
    logic [IN_W-1:0] one_count = '0;
    logic [IN_W-1:0] run_limit = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [VAL_W-1:0] sequence_count;

    // Requests waiting to be driven, and the counts expected back in order.
    count_request_t request_queue[$];
    expected_result_t expected_counts[$];

    // Prefix count tables of the predictor, indexed by zeros and ones used.
    logic [VAL_W-1:0] ends_in_zero [0:SIDE-1][0:SIDE-1];
    logic [VAL_W-1:0] ends_in_one [0:SIDE-1][0:SIDE-1];

    int requests_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int limit_zero_sent = 0;
    int saturated_sent = 0;

    int burst_left = 0;
    int gap_left = 0;
    count_request_t next_req;
    expected_result_t new_expect;
    expected_result_t head_expect;

    int hold_left = 0;
    bit hold_done = 1'b0;
    int mode_left = 0;
    int ready_mode = 0;
    bit ready_next;

    run_limited_binary_count_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .zero_count     (zero_count),
        .one_count      (one_count),
        .run_limit      (run_limit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sequence_count (sequence_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // (a + b - c) modulo the prime, with all three already reduced.
    function automatic logic [VAL_W-1:0] mod_add_sub(input logic [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b,
                                                     input logic [VAL_W-1:0] c);
        longint unsigned sum;
        sum = longint'(a) + longint'(b) + longint'(PRIME_MOD) - longint'(c);
        return VAL_W'(sum % longint'(PRIME_MOD));
    endfunction

    // Counts sequences with the given numbers of zeros and ones and no run
    // longer than the limit. Each cell splits the count by last symbol, and
    // the cell a full run back is subtracted to cut runs that grow too long.
    function automatic logic [VAL_W-1:0] count_bounded_runs(input count_request_t req);
        int unsigned nz;
        int unsigned no;
        int unsigned lim;
        int unsigned i;
        int unsigned j;
        logic [VAL_W-1:0] drop_zero;
        logic [VAL_W-1:0] drop_one;
        nz = (req.zeros > MAX_SYM) ? MAX_SYM : req.zeros;
        no = (req.ones > MAX_SYM) ? MAX_SYM : req.ones;
        lim = req.limit;
        for (i = 0; i <= nz; i++)
        begin
            ends_in_zero[i][0] = (i <= lim) ? VAL_W'(1) : '0;
            ends_in_one[i][0] = (i == 0) ? VAL_W'(1) : '0;
        end
        for (j = 1; j <= no; j++)
        begin
            ends_in_zero[0][j] = '0;
            ends_in_one[0][j] = (j <= lim) ? VAL_W'(1) : '0;
        end
        for (i = 1; i <= nz; i++)
        begin
            for (j = 1; j <= no; j++)
            begin
                drop_zero = (i > lim) ? ends_in_one[i-1-lim][j] : '0;
                drop_one = (j > lim) ? ends_in_zero[i][j-1-lim] : '0;
                ends_in_zero[i][j] = mod_add_sub(ends_in_zero[i-1][j], ends_in_one[i-1][j],
                                                 drop_zero);
                ends_in_one[i][j] = mod_add_sub(ends_in_zero[i][j-1], ends_in_one[i][j-1],
                                                drop_one);
            end
        end
        return mod_add_sub(ends_in_zero[nz][no], ends_in_one[nz][no], '0);
    endfunction

    task automatic queue_request(input int zeros, input int ones, input int limit);
        count_request_t req;
        req.zeros = IN_W'(zeros);
        req.ones = IN_W'(ones);
        req.limit = IN_W'(limit);
        request_queue.push_back(req);
    endtask

    // Mostly small tables; now and then one count spans the full field
    // width against a tiny other count, or both counts are moderate.
    function automatic count_request_t random_request();
        count_request_t req;
        int size_kind;
        int limit_kind;
        size_kind = $urandom_range(0, 19);
        if (size_kind == 0)
        begin
            req.zeros = IN_W'($urandom_range(0, 511));
            req.ones = IN_W'($urandom_range(0, 2));
        end
        else if (size_kind == 1)
        begin
            req.zeros = IN_W'($urandom_range(0, 2));
            req.ones = IN_W'($urandom_range(0, 511));
        end
        else if (size_kind == 2)
        begin
            req.zeros = IN_W'($urandom_range(17, 48));
            req.ones = IN_W'($urandom_range(17, 48));
        end
        else
        begin
            req.zeros = IN_W'($urandom_range(0, 16));
            req.ones = IN_W'($urandom_range(0, 16));
        end
        limit_kind = $urandom_range(0, 9);
        if (limit_kind < 6)
            req.limit = IN_W'($urandom_range(1, 6));
        else if (limit_kind < 8)
            req.limit = IN_W'($urandom_range(1, 20));
        else
            req.limit = IN_W'($urandom_range(0, 511));
        return req;
    endfunction

    // Driver: offers queued requests in bursts separated by random gaps and
    // predicts the count of each request at its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            zero_count <= '0;
            one_count <= '0;
            run_limit <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                new_expect.req.zeros = zero_count;
                new_expect.req.ones = one_count;
                new_expect.req.limit = run_limit;
                new_expect.count = count_bounded_runs(new_expect.req);
                expected_counts.push_back(new_expect);
                requests_sent++;
                if (run_limit == 0)
                    limit_zero_sent++;
                if (zero_count > MAX_SYM || one_count > MAX_SYM)
                    saturated_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    next_req = request_queue.pop_front();
                    zero_count <= next_req.zeros;
                    one_count <= next_req.ones;
                    run_limit <= next_req.limit;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction and
    // drives out_ready from a changing stall pattern plus one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_counts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Result %0d arrived with no request outstanding",
                                 sequence_count);
                end
                else
                begin
                    head_expect = expected_counts.pop_front();
                    if (sequence_count !== head_expect.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("Count mismatch for zeros=%0d ones=%0d limit=%0d: %s %0d, %s %0d",
                                     head_expect.req.zeros, head_expect.req.ones,
                                     head_expect.req.limit, "expected", head_expect.count,
                                     "got", sequence_count);
                    end
                end
            end

            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            else
                mode_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ready_next = 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) == 0);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ($urandom_range(0, 9) != 0);
                endcase
            end
            out_ready <= ready_next;
        end
    end

    // Waits until every queued request has gone out and every count is back.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || in_valid || expected_counts.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty sequences, a run limit of zero, and tiny cases.
        queue_request(0, 0, 1);
        queue_request(0, 0, 0);
        queue_request(1, 0, 0);
        queue_request(0, 1, 0);
        queue_request(3, 3, 0);
        queue_request(1, 1, 1);
        queue_request(5, 5, 1);
        // Limits above the counts, and limits that bite.
        queue_request(4, 4, 511);
        queue_request(6, 2, 2);
        queue_request(2, 6, 3);
        queue_request(10, 12, 2);
        queue_request(7, 7, 7);
        // Largest legal counts on one side, then counts that saturate.
        queue_request(256, 0, 256);
        queue_request(0, 256, 255);
        queue_request(511, 0, 511);
        queue_request(0, 511, 1);
        queue_request(511, 1, 100);
        queue_request(1, 511, 256);
        queue_request(257, 2, 7);
        // Full tables on both sides, then a large uneven one.
        queue_request(256, 256, 1);
        queue_request(256, 256, 256);
        queue_request(170, 85, 3);
        wait_for_drain();

        // Random requests in two phases with a full drain in between.
        repeat (2)
        begin
            repeat (RANDOM_PER_PHASE) request_queue.push_back(random_request());
            wait_for_drain();
        end

        repeat (50) @(negedge clk);
        if (expected_counts.size() != 0)
            mismatch_count += expected_counts.size();

        $display("Checked %0d results for %0d requests, %0d with a run limit of zero",
                 results_seen, requests_sent, limit_zero_sent);
        $display("and %0d with a saturating count, under bursty input and stalled output.",
                 saturated_sent);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("Timed out with %0d counts still outstanding", expected_counts.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
